[design/srr_pkg.sv]
// Package for the selective-repeat receiver: sizing constants, result kind codes
// and the packet and result beat structs.
// No dependencies; every other design file imports it.
package srr_pkg;

    localparam int SEQ_SPACE    = 8;
    localparam int WINDOW       = 4;
    localparam int PAYLOAD_BITS = 64;

    localparam int SLOT_W  = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int EFF_WIN = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE;
    // previous window only exists while the window is smaller than the space
    localparam bit PREV_EN = (WINDOW < SEQ_SPACE);

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [7:0]  seq_num;
        logic        checksum_good;
        logic [63:0] payload_word;
    } srr_pkt_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_seq;
        logic [63:0] out_payload;
        logic        last;
    } srr_res_t;

endpackage

[design/srr_mem.sv]
// Payload buffer: one entry per sequence number, one write and one registered read.
// Depends on srr_pkg for sizes.
module srr_mem (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [srr_pkg::SLOT_W-1:0]       wr_addr,
    input  logic [srr_pkg::PAYLOAD_BITS-1:0] wr_data,
    input  logic [srr_pkg::SLOT_W-1:0]       rd_addr,
    output logic [srr_pkg::PAYLOAD_BITS-1:0] rd_data
);
    import srr_pkg::*;

    logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/srr_ctrl.sv]
// Receiver sequencer: window classification through one shared modular
// subtractor, received marks, window base and one result beat per cycle
// while res_ready is high. Uses srr_pkg; drives payload buffer srr_mem.
module srr_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pkt_valid,
    output logic                             pkt_ready,
    input  srr_pkg::srr_pkt_t                pkt,
    output logic                             res_valid,
    input  logic                             res_ready,
    output srr_pkg::srr_res_t                res,
    output logic                             wr_en,
    output logic [srr_pkg::SLOT_W-1:0]       wr_addr,
    output logic [srr_pkg::PAYLOAD_BITS-1:0] wr_data,
    output logic [srr_pkg::SLOT_W-1:0]       rd_addr,
    input  logic [srr_pkg::PAYLOAD_BITS-1:0] rd_data
);
    import srr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_FWD,
        ST_ACK,
        ST_DELIVER
    } state_t;

    localparam logic [SLOT_W:0] SPACE_EXT = (SLOT_W+1)'(SEQ_SPACE);
    localparam logic [SLOT_W:0] WIN_EXT   = (SLOT_W+1)'(EFF_WIN);
    localparam logic [8:0]      SPACE_9   = 9'(SEQ_SPACE);

    state_t                  state_reg;
    logic [SLOT_W-1:0]       base_reg;
    logic [SEQ_SPACE-1:0]    marks_reg;
    logic [SLOT_W:0]         cnt_reg;
    logic                    ack_only_reg;
    logic [SLOT_W-1:0]       seq_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    logic                    accept;
    logic                    pkt_ok;
    logic [SLOT_W-1:0]       op_a, op_b;
    logic [SLOT_W:0]         diff_raw, diff;
    logic [SLOT_W-1:0]       base_inc;
    logic [SLOT_W-1:0]       base_next;
    logic                    fire;
    logic                    ack_last, dlv_last;

    assign pkt_ready = (state_reg == ST_IDLE);
    assign accept    = pkt_valid && pkt_ready;
    assign pkt_ok    = pkt.checksum_good && ({1'b0, pkt.seq_num} < SPACE_9);

    // shared modular subtractor: (a - b) mod SEQ_SPACE
    always_comb
    begin
        if (state_reg == ST_BACK)
        begin
            op_a = base_reg;
            op_b = seq_reg;
        end
        else
        begin
            op_a = seq_reg;
            op_b = base_reg;
        end
        diff_raw = {1'b0, op_a} + SPACE_EXT - {1'b0, op_b};
        diff     = (diff_raw >= SPACE_EXT) ? diff_raw - SPACE_EXT : diff_raw;
    end

    assign base_inc = ({1'b0, base_reg} == SPACE_EXT - 1'b1) ? '0 : base_reg + 1'b1;

    assign ack_last = ack_only_reg || !marks_reg[base_reg];
    assign dlv_last = (cnt_reg + 1'b1 == WIN_EXT) || !marks_reg[base_inc];

    assign res_valid = (state_reg == ST_ACK) || (state_reg == ST_DELIVER);
    assign fire      = res_valid && res_ready;

    always_comb
    begin
        if (state_reg == ST_DELIVER)
        begin
            res.kind        = KIND_DELIVER;
            res.out_seq     = 8'(base_reg);
            res.out_payload = 64'(rd_data);
            res.last        = dlv_last;
        end
        else
        begin
            res.kind        = KIND_ACK;
            res.out_seq     = 8'(seq_reg);
            res.out_payload = '0;
            res.last        = ack_last;
        end
    end

    // read data always tracks the entry at the current base
    assign base_next = (state_reg == ST_DELIVER && fire) ? base_inc : base_reg;
    assign rd_addr   = base_next;

    assign wr_en   = (state_reg == ST_FWD) && (diff < WIN_EXT);
    assign wr_addr = seq_reg;
    assign wr_data = pay_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seq_reg <= SLOT_W'(pkt.seq_num);
            pay_reg <= PAYLOAD_BITS'(pkt.payload_word);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            base_reg     <= '0;
            marks_reg    <= '0;
            cnt_reg      <= '0;
            ack_only_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && pkt_ok)
                    begin
                        state_reg <= ST_BACK;
                    end
                end
                ST_BACK:
                begin
                    if (PREV_EN && diff != '0 && diff <= WIN_EXT)
                    begin
                        ack_only_reg <= 1'b1;
                        state_reg    <= ST_ACK;
                    end
                    else
                    begin
                        state_reg <= ST_FWD;
                    end
                end
                ST_FWD:
                begin
                    if (diff < WIN_EXT)
                    begin
                        marks_reg[seq_reg] <= 1'b1;
                        ack_only_reg       <= 1'b0;
                        state_reg          <= ST_ACK;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ACK:
                begin
                    if (fire)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ack_last ? ST_IDLE : ST_DELIVER;
                    end
                end
                ST_DELIVER:
                begin
                    if (fire)
                    begin
                        marks_reg[base_reg] <= 1'b0;
                        base_reg            <= base_inc;
                        cnt_reg             <= cnt_reg + 1'b1;
                        if (dlv_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[design/selective_repeat_receiver.sv]
// Selective-repeat ARQ receiver, top level: sequencer, payload buffer and
// the result output register. Depends on srr_pkg, srr_ctrl and srr_mem.
//
// Usage:
//   pkt channel (pkt_valid/pkt_ready/pkt) takes one packet beat: sequence
//   number, checksum flag, payload word. res channel (res_valid/res_ready/res)
//   gives result beats: an acknowledgement first, then in-order deliveries
//   from the window base; last marks the final beat of a packet.
//   A packet with a bad checksum, an out-of-range sequence number or one
//   outside both windows gives no beats and frees the input again.
//   An in-window packet passes acceptance and the shared modular subtractor
//   twice, then gives one result beat per cycle while res_ready is high
//   (1 + up to WINDOW beats); a re-acknowledged packet passes it once.
//   pkt_ready is low until the last beat has moved into the output register.
//   The first beat is registered out after ST_BACK and ST_FWD (re-ack: ST_BACK).
//   Reset clears the window base to 0 and all received marks; buffer
//   contents are not cleared and are only read after being written.
//   While res_ready is low a beat held in the output register stays there and
//   the sequencer waits; nothing is lost or repeated.
module selective_repeat_receiver (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pkt_valid,
    output logic              pkt_ready,
    input  srr_pkg::srr_pkt_t pkt,
    output logic              res_valid,
    input  logic              res_ready,
    output srr_pkg::srr_res_t res
);
    import srr_pkg::*;

    logic                    int_valid;
    logic                    int_ready;
    srr_res_t                int_res;
    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_addr;
    logic [PAYLOAD_BITS-1:0] wr_data;
    logic [SLOT_W-1:0]       rd_addr;
    logic [PAYLOAD_BITS-1:0] rd_data;

    logic                    out_valid_reg;
    srr_res_t                out_reg;

    srr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (int_valid),
        .res_ready (int_ready),
        .res       (int_res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    srr_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register takes a new beat whenever it is empty or being drained
    assign int_ready = !out_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (int_ready)
        begin
            out_valid_reg <= int_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (int_ready && int_valid)
        begin
            out_reg <= int_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

[tb/selective_repeat_receiver_tb.sv]
`timescale 1ns / 100ps
// Testbench for selective_repeat_receiver: a directed packet table, then random packet
// streams under four idling phases, each beat checked against table/model beats.
// Depends on srr_pkg and the design files.
module selective_repeat_receiver_tb;
    import srr_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8 * (4 + EFF_WIN);
    localparam int PHASE_ITEMS  = 28;
    localparam int N_ROWS       = 21;
    localparam logic [63:0] PAY_MASK = {64{1'b1}} >> (64 - PAYLOAD_BITS);

    typedef enum logic [1:0] {ROW_PREDICT, ROW_DROP, ROW_REACK, ROW_FIRST} row_mode_t;

    typedef struct {
        logic [7:0]  seq;
        logic        good;
        logic [63:0] pay;
        row_mode_t   mode;
    } pkt_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     pkt_valid = 1'b0;
    logic     pkt_ready;
    srr_pkt_t pkt       = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    srr_res_t res;

    // receive window as the model sees it
    logic [7:0]  base_q;
    logic        got_mark [SEQ_SPACE];
    logic [63:0] slot_data [SEQ_SPACE];

    srr_res_t owed_beats [$];
    srr_res_t want_beat;
    int       errors        = 0;
    int       idle_cycles   = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;
    int       idle_tab [4]  = '{0, 74, 0, 38};
    int       stall_tab [4] = '{0, 0, 74, 38};
    pkt_row_t dir_rows [N_ROWS];

    selective_repeat_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Updates the window for one accepted packet; returns the number of beats it causes.
    function automatic int rx_packet(input srr_pkt_t p, input bit queue_it);
        int       back;
        int       fwd;
        int       base;
        int       n;
        int       i;
        srr_res_t beat;
        if (!p.checksum_good || p.seq_num >= SEQ_SPACE)
            return 0;
        base = int'(base_q) % SEQ_SPACE;
        back = (base + SEQ_SPACE - int'(p.seq_num)) % SEQ_SPACE;
        fwd  = (int'(p.seq_num) + SEQ_SPACE - base) % SEQ_SPACE;
        // previous window is tested first: re-ack only
        if (PREV_EN && back >= 1 && back <= WINDOW)
        begin
            beat = '{KIND_ACK, p.seq_num, 64'd0, 1'b1};
            if (queue_it)
                owed_beats.push_back(beat);
            return 1;
        end
        if (fwd >= EFF_WIN)
            return 0;
        slot_data[p.seq_num] = p.payload_word & PAY_MASK;
        got_mark[p.seq_num]  = 1'b1;
        beat = '{KIND_ACK, p.seq_num, 64'd0, 1'b0};
        n = 1;
        // hold each beat back one step so the final one can carry last
        for (i = 0; i < EFF_WIN; i++)
        begin
            if (!got_mark[base])
                break;
            if (queue_it)
                owed_beats.push_back(beat);
            beat = '{KIND_DELIVER, 8'(base), slot_data[base], 1'b0};
            got_mark[base] = 1'b0;
            base = (base + 1) % SEQ_SPACE;
            n++;
        end
        base_q    = 8'(base);
        beat.last = 1'b1;
        if (queue_it)
            owed_beats.push_back(beat);
        return n;
    endfunction

    // Mostly in-window packets so deliveries keep flowing; the rest is noise.
    function automatic srr_pkt_t random_pkt();
        srr_pkt_t p;
        int       pick;
        pick            = $urandom_range(0, 99);
        p.payload_word  = {$urandom, $urandom};
        p.checksum_good = 1'b1;
        if (pick < 70)
            p.seq_num = 8'((int'(base_q) + $urandom_range(0, EFF_WIN - 1)) % SEQ_SPACE);
        else if (pick < 80 && PREV_EN)
            p.seq_num = 8'((int'(base_q) + SEQ_SPACE - $urandom_range(1, WINDOW)) % SEQ_SPACE);
        else if (pick < 90)
        begin
            p.seq_num       = 8'($urandom_range(0, 255));
            p.checksum_good = 1'b0;
        end
        else
            p.seq_num = 8'($urandom_range(SEQ_SPACE, 255));
        return p;
    endfunction

    // Holds valid until the beat is taken; valid is not dropped between back-to-back beats.
    task automatic send_pkt(input srr_pkt_t p, input bit queue_it, output int n);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            pkt_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        pkt       <= p;
        pkt_valid <= 1'b1;
        @(posedge clk);
        while (!pkt_ready)
            @(posedge clk);
        n = rx_packet(p, queue_it);
    endtask

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (owed_beats.size() == 0)
            begin
                $error("unexpected result beat: kind %0d seq %0d", res.kind, res.out_seq);
                errors++;
            end
            else
            begin
                want_beat = owed_beats.pop_front();
                if (res.kind !== want_beat.kind)
                begin
                    $error("kind: expected %0d, got %0d", want_beat.kind, res.kind);
                    errors++;
                end
                if (res.out_seq !== want_beat.out_seq)
                begin
                    $error("out_seq: expected %0d, got %0d", want_beat.out_seq, res.out_seq);
                    errors++;
                end
                if (res.out_payload !== want_beat.out_payload)
                begin
                    $error("out_payload: expected %h, got %h",
                           want_beat.out_payload, res.out_payload);
                    errors++;
                end
                if (res.last !== want_beat.last)
                begin
                    $error("last: expected %0d, got %0d", want_beat.last, res.last);
                    errors++;
                end
            end
        end
    end

    // counts cycles in which neither channel moves a beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pkt_valid && pkt_ready) || (res_valid && res_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("selective_repeat_receiver test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        srr_pkt_t p;
        int       n;
        int       counted;

        base_q = '0;
        for (int s = 0; s < SEQ_SPACE; s++)
        begin
            got_mark[s]  = 1'b0;
            slot_data[s] = '0;
        end

        // base starts at 0; comments give the base before each group
        dir_rows = '{
            '{8'd0,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ROW_FIRST},
            // base 1
            '{8'd0,   1'b1, 64'h0000_0000_0000_0000, ROW_REACK},
            '{8'd255, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ROW_DROP},
            '{8'd8,   1'b1, 64'h1234_5678_9ABC_DEF0, ROW_DROP},
            '{8'd1,   1'b0, 64'hFFFF_FFFF_FFFF_FFFF, ROW_DROP},
            '{8'd5,   1'b1, 64'hDEAD_BEEF_0000_0001, ROW_REACK},
            '{8'd4,   1'b1, 64'h0000_0000_0000_0000, ROW_PREDICT},
            '{8'd3,   1'b1, 64'hAAAA_AAAA_AAAA_AAAA, ROW_PREDICT},
            '{8'd3,   1'b1, 64'h5555_5555_5555_5555, ROW_PREDICT},
            '{8'd2,   1'b1, 64'h0123_4567_89AB_CDEF, ROW_PREDICT},
            '{8'd1,   1'b1, 64'h0000_0000_0000_0000, ROW_PREDICT},
            // base 5
            '{8'd4,   1'b1, 64'h8000_0000_0000_0001, ROW_REACK},
            '{8'd1,   1'b1, 64'h7FFF_FFFF_FFFF_FFFE, ROW_REACK},
            '{8'd7,   1'b1, 64'hFEDC_BA98_7654_3210, ROW_PREDICT},
            '{8'd6,   1'b1, 64'h0F0F_0F0F_0F0F_0F0F, ROW_PREDICT},
            '{8'd5,   1'b1, 64'hF0F0_F0F0_F0F0_F0F0, ROW_PREDICT},
            // base 0 after wrap
            '{8'd0,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ROW_PREDICT},
            '{8'd128, 1'b0, 64'h0000_0000_0000_0000, ROW_DROP},
            '{8'd7,   1'b0, 64'h1111_2222_3333_4444, ROW_DROP},
            '{8'd2,   1'b1, 64'h5A5A_5A5A_A5A5_A5A5, ROW_PREDICT},
            '{8'd1,   1'b1, 64'hC3C3_3C3C_C3C3_3C3C, ROW_PREDICT}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            p = '{dir_rows[r].seq, dir_rows[r].good, dir_rows[r].pay};
            send_pkt(p, dir_rows[r].mode == ROW_PREDICT, n);
            unique case (dir_rows[r].mode)
                ROW_REACK:
                    owed_beats.push_back(srr_res_t'{KIND_ACK, p.seq_num, 64'd0, 1'b1});
                ROW_FIRST:
                begin
                    owed_beats.push_back(srr_res_t'{KIND_ACK, p.seq_num, 64'd0, 1'b0});
                    owed_beats.push_back(srr_res_t'{KIND_DELIVER, p.seq_num,
                                                    p.payload_word, 1'b1});
                end
                default: ;
            endcase
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_tab[ph];
            stall_pct     = stall_tab[ph];
            counted       = 0;
            // dropped packets do not count toward the phase
            while (counted < PHASE_ITEMS)
            begin
                send_pkt(random_pkt(), 1'b1, n);
                if (n > 0)
                    counted++;
            end
        end
        pkt_valid <= 1'b0;

        while (owed_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("selective_repeat_receiver test passed");
        else
            $display("selective_repeat_receiver test failed");
        $finish;
    end

endmodule

[sim.f]
design/srr_pkg.sv
design/srr_mem.sv
design/srr_ctrl.sv
design/selective_repeat_receiver.sv
tb/selective_repeat_receiver_tb.sv
